[hw/rtl/ellipse_point_generator_top_defines.svh]
// Assertion macros for the ellipse point generator.
// Include with the bare file name; needs aclk and aresetn in scope.
`ifndef ELLIPSE_POINT_GENERATOR_TOP_DEFINES_SVH
`define ELLIPSE_POINT_GENERATOR_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define EPG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("epg assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define EPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("epg assertion failed");

`endif

[hw/rtl/epg_pkg.sv]
// Shared types, constants and the arctangent table of the ellipse point generator.
// No dependencies.
package epg_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int INDEX_BITS_DEF   = 18;
    localparam int ATAN_ENTRIES     = 30;

    localparam int STEP_W     = 29;  // step = 2^28 / m fits 29 bits
    localparam int DIV_STEPS  = 29;  // one quotient bit per cycle
    localparam int RAD_W      = 14;
    localparam int CTR_W      = 16;
    localparam int PT_W       = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TRIG_W     = 33;  // Q30 with headroom
    localparam int ANG_W      = 32;  // signed Q29 angle inside the CORDIC

    localparam logic [ANG_W:0] TWO_PI_Q29        = 33'd3373259426;
    localparam logic [ANG_W:0] PI_Q29            = 33'd1686629713;
    localparam logic [ANG_W:0] HALF_PI_Q29       = 33'd843314857;
    localparam logic [ANG_W:0] THREE_HALF_PI_Q29 = 33'd2529944570;
    localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 33'sd652032875;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_RADIUS_X = 2'd2,
        CFG_RADIUS_Y = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic valid;
        logic neg;
        logic in_range;
        logic is_last;
    } epg_ctl_t;

    function automatic logic signed [ANG_W-1:0] atan_q29(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 32'sd421657428;
            1:  v = 32'sd248918915;
            2:  v = 32'sd131521918;
            3:  v = 32'sd66762579;
            4:  v = 32'sd33510843;
            5:  v = 32'sd16771758;
            6:  v = 32'sd8387925;
            7:  v = 32'sd4194219;
            8:  v = 32'sd2097141;
            9:  v = 32'sd1048575;
            default: begin
                if (idx < ATAN_ENTRIES) begin
                    v = 32'sd1 <<< (29 - idx);
                end else begin
                    v = '0;
                end
            end
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/epg_step_div.sv]
// Bit-serial restoring divider: angle step = 2^28 / max radius.
// Depends on epg_pkg.
module epg_step_div
    import epg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  divisor,
    output logic              busy,
    output logic [STEP_W-1:0] quot
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [RAD_W:0]    rem_reg;
    logic [STEP_W-1:0] q_reg;
    logic [STEP_W-1:0] quot_reg;

    logic [RAD_W+1:0]  rem_shift;
    logic [RAD_W+1:0]  rem_diff;
    logic              ge;
    logic [RAD_W:0]    rem_next;
    logic [STEP_W-1:0] q_next;

    // Dividend is a single one at bit 28: feed it on the first step only.
    assign rem_shift = {rem_reg, (cnt_reg == CNT_W'(DIV_STEPS))};
    assign ge        = rem_shift >= {2'b00, divisor};
    assign rem_diff  = rem_shift - {2'b00, divisor};
    assign rem_next  = ge ? rem_diff[RAD_W:0] : rem_shift[RAD_W:0];
    assign q_next    = {q_reg[STEP_W-2:0], ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            quot_reg <= STEP_W'(1) << (STEP_W - 1);
        end else if (start) begin
            cnt_reg <= CNT_W'(DIV_STEPS);
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                quot_reg <= q_next;
            end
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;

endmodule

[hw/rtl/epg_cordic_stage.sv]
// One rotation-mode CORDIC iteration, registered.
// Depends on epg_pkg.
module epg_cordic_stage
    import epg_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     adv,
    input  epg_ctl_t                 ctl_i,
    input  logic signed [TRIG_W-1:0] x_i,
    input  logic signed [TRIG_W-1:0] y_i,
    input  logic signed [ANG_W-1:0]  z_i,
    output epg_ctl_t                 ctl_o,
    output logic signed [TRIG_W-1:0] x_o,
    output logic signed [TRIG_W-1:0] y_o,
    output logic signed [ANG_W-1:0]  z_o
);

    localparam logic signed [ANG_W-1:0] ATAN = atan_q29(STAGE);

    epg_ctl_t                 ctl_reg;
    logic signed [TRIG_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]  z_reg;
    logic signed [TRIG_W-1:0] dx, dy;

    // Arithmetic shift floors toward minus infinity.
    assign dx = y_i >>> STAGE;
    assign dy = x_i >>> STAGE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (adv) begin
            ctl_reg <= ctl_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (!z_i[ANG_W-1]) begin
                x_reg <= x_i - dx;
                y_reg <= y_i + dy;
                z_reg <= z_i - ATAN;
            end else begin
                x_reg <= x_i + dx;
                y_reg <= y_i - dy;
                z_reg <= z_i + ATAN;
            end
        end
    end

    assign ctl_o = ctl_reg;
    assign x_o   = x_reg;
    assign y_o   = y_reg;
    assign z_o   = z_reg;

endmodule

[hw/rtl/epg_scale.sv]
// Radius scaling, rounding to Q8 and centre offset for one axis, two stages.
// Depends on epg_pkg.
module epg_scale
    import epg_pkg::*;
(
    input  logic                     aclk,
    input  logic                     adv,
    input  logic [RAD_W-1:0]         rad,
    input  logic signed [TRIG_W-1:0] trig,
    input  logic signed [CTR_W-1:0]  ctr,
    input  logic                     keep,
    output logic signed [PT_W-1:0]   pt
);

    localparam int PROD_W = RAD_W + 1 + TRIG_W;
    localparam int RND_W  = PROD_W - 22;
    localparam int SUM_W  = RND_W + 1;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CTR_W-1:0]  ctr_reg;
    logic                     keep_reg;
    logic signed [PT_W-1:0]   pt_reg;

    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;

    assign prod_rnd = prod_reg + PROD_W'(signed'(1) <<< 21);
    assign rnd      = RND_W'(prod_rnd >>> 22);
    // Centre in Q8, sign-extended to the sum width.
    assign sum      = SUM_W'(rnd) + SUM_W'($signed({ctr_reg, 8'h00}));

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= PROD_W'($signed({1'b0, rad})) * PROD_W'(trig);
            ctr_reg  <= ctr;
            keep_reg <= keep;
            pt_reg   <= keep_reg ? sum[PT_W-1:0] : '0;
        end
    end

    assign pt = pt_reg;

endmodule

[hw/rtl/ellipse_point_generator_top.sv]
// Ellipse point generator top level: config registers, step divider,
// angle pipeline, CORDIC chain and output scaling. Depends on epg_pkg and the defines header.
//
//   channel   ports                        handshake
//   -------   --------------------------   ----------------------
//   input     s_point_index                s_valid / s_ready
//   result    m_point_x/y, in_range, last  m_valid / m_ready
//   config    cfg_wr_index, cfg_wr_data    cfg_wr_en, no wait
//
// Takes one item per clock while s_ready is high; registers in order: input, multiply,
// fold, one register per CORDIC iteration, scale multiply, round and offset.
// A radius write starts the bit-serial step divider: after it, s_ready stays low until
// the divider has finished. Reset is synchronous; it clears all valid bits and loads
// the step for a radius of one, so no pass is needed.
// When the output item is not taken, the whole pipeline holds; nothing is dropped.
`include "ellipse_point_generator_top_defines.svh"

module ellipse_point_generator_top
    import epg_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [INDEX_BITS-1:0]  s_point_index,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [PT_W-1:0] m_point_x,
    output logic signed [PT_W-1:0] m_point_y,
    output logic                   m_in_range,
    output logic                   m_is_last
);

    localparam int A_W = INDEX_BITS + STEP_W;

    // ---------------- configuration ----------------
    logic signed [CTR_W-1:0] center_x_reg, center_y_reg;
    logic [RAD_W-1:0]        radius_x_reg, radius_y_reg;
    logic                    div_start_reg;
    logic                    div_busy;
    logic [STEP_W-1:0]       step;
    logic [RAD_W-1:0]        rad_max, rad_div;
    logic                    rad_wr;

    assign rad_wr = cfg_wr_en && (cfg_wr_index == CFG_RADIUS_X ||
                                  cfg_wr_index == CFG_RADIUS_Y);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_x_reg  <= RAD_W'(1);
            radius_y_reg  <= RAD_W'(1);
            div_start_reg <= 1'b0;
        end else begin
            div_start_reg <= rad_wr;
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    CFG_CENTER_X: center_x_reg <= cfg_wr_data[CTR_W-1:0];
                    CFG_CENTER_Y: center_y_reg <= cfg_wr_data[CTR_W-1:0];
                    CFG_RADIUS_X: radius_x_reg <= cfg_wr_data[RAD_W-1:0];
                    CFG_RADIUS_Y: radius_y_reg <= cfg_wr_data[RAD_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Step uses the larger radius; both zero acts as one.
    assign rad_max = (radius_x_reg > radius_y_reg) ? radius_x_reg : radius_y_reg;
    assign rad_div = (rad_max == '0) ? RAD_W'(1) : rad_max;

    epg_step_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .divisor (rad_div),
        .busy    (div_busy),
        .quot    (step)
    );

    // ---------------- pipeline control ----------------
    epg_ctl_t out_ctl_reg;
    logic     adv;

    // Advance the whole pipeline unless a finished item waits at the output and m_ready is low.
    assign adv     = !out_ctl_reg.valid || m_ready;
    assign s_ready = adv && !div_busy && !div_start_reg;

    // Input register.
    logic                  v0_reg;
    logic [INDEX_BITS-1:0] k_reg;
    // Angle product.
    logic                  v1_reg;
    logic [A_W-1:0]        a_reg;
    // Folded angle.
    epg_ctl_t              ctl2_reg;
    logic signed [ANG_W-1:0] z2_reg;

    logic [A_W-1:0]        a_next;
    logic                  in_rng;
    logic                  last_n;
    logic [ANG_W:0]        a_lo;
    logic signed [ANG_W:0] z_fold;
    logic                  neg_n;

    assign a_next = a_reg + A_W'(step);
    assign in_rng = a_reg <= A_W'(TWO_PI_Q29);
    assign last_n = in_rng && (a_next > A_W'(TWO_PI_Q29));
    assign a_lo   = a_reg[ANG_W:0];

    // Fold the angle into [-pi/2, pi/2]; the middle half turn flips sign.
    always_comb begin
        z_fold = signed'(a_lo);
        neg_n  = 1'b0;
        if (a_lo > HALF_PI_Q29) begin
            if (a_lo <= THREE_HALF_PI_Q29) begin
                z_fold = signed'(a_lo - PI_Q29);
                neg_n  = 1'b1;
            end else begin
                z_fold = signed'(a_lo - TWO_PI_Q29);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            ctl2_reg <= '0;
        end else if (adv) begin
            v0_reg            <= s_valid && s_ready;
            v1_reg            <= v0_reg;
            ctl2_reg.valid    <= v1_reg;
            ctl2_reg.neg      <= neg_n;
            ctl2_reg.in_range <= in_rng;
            ctl2_reg.is_last  <= last_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            k_reg  <= s_point_index;
            a_reg  <= A_W'(k_reg) * A_W'(step);
            z2_reg <= z_fold[ANG_W-1:0];
        end
    end

    // ---------------- CORDIC chain ----------------
    epg_ctl_t                 cctl [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] cx   [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] cy   [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]  cz   [CORDIC_STEPS+1];

    assign cctl[0] = ctl2_reg;
    assign cx[0]   = GAIN_Q30;
    assign cy[0]   = '0;
    assign cz[0]   = z2_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        epg_cordic_stage #(.STAGE(i)) u_stage (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .ctl_i   (cctl[i]),
            .x_i     (cx[i]),
            .y_i     (cy[i]),
            .z_i     (cz[i]),
            .ctl_o   (cctl[i+1]),
            .x_o     (cx[i+1]),
            .y_o     (cy[i+1]),
            .z_o     (cz[i+1])
        );
    end

    // ---------------- scaling and output ----------------
    epg_ctl_t                 ctl_s_reg;
    epg_ctl_t                 cend;
    logic signed [TRIG_W-1:0] cos_v, sin_v;

    assign cend  = cctl[CORDIC_STEPS];
    assign cos_v = cend.neg ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
    assign sin_v = cend.neg ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];

    epg_scale u_scale_x (
        .aclk (aclk),
        .adv  (adv),
        .rad  (radius_x_reg),
        .trig (cos_v),
        .ctr  (center_x_reg),
        .keep (cend.in_range),
        .pt   (m_point_x)
    );

    epg_scale u_scale_y (
        .aclk (aclk),
        .adv  (adv),
        .rad  (radius_y_reg),
        .trig (sin_v),
        .ctr  (center_y_reg),
        .keep (cend.in_range),
        .pt   (m_point_y)
    );

    // Track flags alongside the two scaling stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_s_reg   <= '0;
            out_ctl_reg <= '0;
        end else if (adv) begin
            ctl_s_reg   <= cend;
            out_ctl_reg <= ctl_s_reg;
        end
    end

    assign m_valid    = out_ctl_reg.valid;
    assign m_in_range = out_ctl_reg.in_range;
    assign m_is_last  = out_ctl_reg.is_last;

    // ---------------- assertions ----------------
    `EPG_ASSERT_NEXT(a_rad_wr_blocks_input, rad_wr, !s_ready)
    `EPG_ASSERT_SAME(a_last_needs_range, m_valid && m_is_last, m_in_range)
    `EPG_ASSERT_SAME(a_out_of_range_zero, m_valid && !m_in_range,
                     m_point_x == '0 && m_point_y == '0)
    `EPG_ASSERT_SAME(a_step_nonzero, !div_busy, step != '0)

endmodule
